// File: rtl/bbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and helpers of the Bayer bilinear demosaic
// Field widths, site codes, register indexes and the colour interpolation.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned RAW_W          = 10;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned DIM_W          = 13;
  localparam int unsigned FIFO_DEPTH     = 8;
  localparam int unsigned FIFO_AW        = $clog2(FIFO_DEPTH);

  typedef logic [RAW_W-1:0] raw_t;
  typedef raw_t [2:0][2:0] win_t;

  typedef enum logic [1:0] {
    SITE_B  = 2'd0,
    SITE_GB = 2'd1,
    SITE_GR = 2'd2,
    SITE_R  = 2'd3
  } site_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             run_last;
    logic             frame_last;
  } pix_t;

  typedef struct packed {
    logic vld;
    logic flush;
    logic row1;
    logic y_odd;
    logic x_odd;
    logic first_col;
    logic last_col;
    logic emit_a;
    logic emit_b;
  } s1_ctrl_t;

  function automatic pix_t interp(raw_t hl, raw_t hr, raw_t vt, raw_t vb,
                                  raw_t dtl, raw_t dtr, raw_t dbl, raw_t dbr,
                                  raw_t p, site_t site, logic run_last,
                                  logic frame_last);
    logic [RAW_W:0]   hs;
    logic [RAW_W:0]   vs;
    logic [RAW_W+1:0] hv;
    logic [RAW_W+1:0] ds;
    pix_t             o;
    hs = {1'b0, hl} + {1'b0, hr};
    vs = {1'b0, vt} + {1'b0, vb};
    hv = {1'b0, hs} + {1'b0, vs};
    ds = {2'b00, dtl} + {2'b00, dtr} + {2'b00, dbl} + {2'b00, dbr};
    o.run_last   = run_last;
    o.frame_last = frame_last;
    case (site)
      SITE_B: begin
        o.red   = ds[RAW_W+1:4];
        o.green = hv[RAW_W+1:4];
        o.blue  = p[RAW_W-1:2];
      end
      SITE_GB: begin
        o.red   = vs[RAW_W:3];
        o.green = p[RAW_W-1:2];
        o.blue  = hs[RAW_W:3];
      end
      SITE_GR: begin
        o.red   = hs[RAW_W:3];
        o.green = p[RAW_W-1:2];
        o.blue  = vs[RAW_W:3];
      end
      default: begin
        o.red   = p[RAW_W-1:2];
        o.green = hv[RAW_W+1:4];
        o.blue  = ds[RAW_W+1:4];
      end
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bayer_bilinear_demosaic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic: bilinear demosaic of a BGGR raw stream
// Raw 10-bit samples enter on the in_ channel in raster order, one transfer
// per pixel; after the last row a row of flush items (opcode 1) drains the
// frame. Each item from row one on, but in column zero, yields the pixel
// above-left of it; the last column yields two, so results trail the input by a row.
// Output pixels (8-bit blue, green, red) leave on the out_ channel with
// run_last and frame_last flags.
// Path: a result is registered in the s1_r stage, then held in the queue until taken.
// Throughput: one item per cycle while in_ready is high; the line store
// memory is read at transfer and written back in the next cycle, so every
// item owns one memory slot. A row end from row one on yields two results;
// the queue absorbs the extra one. Items of the wrong kind are taken and dropped.
// Reset: counters, window and queue clear; width 640, height 480. Line
// stores are not cleared and need no clearing time. A cfg_ write restarts
// the frame; the user must do it only while the block is idle; the block does not enforce it.
// Output stall: an eight-entry queue holds results; in_ready drops when it
// cannot take the worst case of the items in flight.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic #(
  parameter int unsigned MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_opcode,
  input  wire logic [bbd_pkg::RAW_W-1:0]   in_raw_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bbd_pkg::PIX_W-1:0]        out_blue,
  output logic [bbd_pkg::PIX_W-1:0]        out_green,
  output logic [bbd_pkg::PIX_W-1:0]        out_red,
  output logic                             out_run_last,
  output logic                             out_frame_last,
  input  wire logic                        cfg_we,
  input  wire bbd_pkg::reg_idx_t           cfg_index,
  input  wire logic [bbd_pkg::DIM_W-1:0]   cfg_wdata
);
  import bbd_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EXT_W = DIM_W + 1;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  s1_ctrl_t         s1_r;
  s1_ctrl_t         s1_nxt;
  raw_t             s1_raw_r;
  logic [CW-1:0]    s1_x_r;

  logic [EXT_W-1:0] eff_w;
  logic [EXT_W-1:0] eff_h;
  logic [CW-1:0]    w_last;
  logic [CW-1:0]    x;
  logic             flush_row;
  logic             last_col;
  logic             row_ge1;
  logic             op_ok;
  logic             take;
  logic [1:0]       s1_n;
  logic [FIFO_AW:0] fifo_count;
  logic [FIFO_AW+1:0] need;

  logic [2*RAW_W-1:0] rd_data;
  raw_t             up;
  raw_t             lo;
  raw_t             nv;
  pix_t             pix_a;
  pix_t             pix_b;
  pix_t             out_pix;

  always_comb begin
    eff_w = {1'b0, width_r};
    if (eff_w < EXT_W'(2)) begin
      eff_w = EXT_W'(2);
    end else if (eff_w > EXT_W'(MAX_WIDTH)) begin
      eff_w = EXT_W'(MAX_WIDTH);
    end
    eff_h = {1'b0, height_r};
    if (eff_h < EXT_W'(2)) begin
      eff_h = EXT_W'(2);
    end else if (eff_h > EXT_W'(MAX_HEIGHT)) begin
      eff_h = EXT_W'(MAX_HEIGHT);
    end
  end

  assign w_last    = CW'(eff_w - EXT_W'(1));
  assign x         = (col_r > w_last) ? w_last : col_r;
  assign flush_row = EXT_W'(row_r) >= eff_h;
  assign last_col  = x == w_last;
  assign row_ge1   = row_r != '0;
  assign op_ok     = in_opcode == (flush_row ? OP_FLUSH : OP_PIXEL);

  // reserve queue room for the worst case of the next item and the one in flight
  assign s1_n     = s1_r.vld ? (2'(s1_r.emit_a) + 2'(s1_r.emit_b)) : 2'd0;
  assign need     = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(s1_n) + (FIFO_AW+2)'(2);
  assign in_ready = need <= (FIFO_AW+2)'(FIFO_DEPTH);
  assign take     = in_valid && in_ready && op_ok;

  always_comb begin
    s1_nxt.vld       = take;
    s1_nxt.flush     = flush_row;
    s1_nxt.row1      = row_r == RW'(1);
    s1_nxt.y_odd     = ~row_r[0];
    s1_nxt.x_odd     = x[0];
    s1_nxt.first_col = x == CW'(1);
    s1_nxt.last_col  = last_col;
    s1_nxt.emit_a    = row_ge1 && (x != '0);
    s1_nxt.emit_b    = row_ge1 && last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      col_r    <= '0;
      row_r    <= '0;
      s1_r     <= '0;
    end else begin
      s1_r <= s1_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default:    width_r  <= width_r;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (take) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= flush_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= x + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_raw_r <= in_raw_value;
      s1_x_r   <= x;
    end
  end

  bbd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (x),
    .rd_data (rd_data),
    .wr_en   (s1_r.vld),
    .wr_addr (s1_x_r),
    .wr_data ({lo, nv})
  );

  assign up = rd_data[2*RAW_W-1:RAW_W];
  assign lo = rd_data[RAW_W-1:0];

  bbd_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (s1_r),
    .raw   (s1_raw_r),
    .up    (up),
    .lo    (lo),
    .nv    (nv),
    .pix_a (pix_a),
    .pix_b (pix_b)
  );

  bbd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (s1_r.vld && s1_r.emit_a),
    .push_b    (s1_r.vld && s1_r.emit_b),
    .data_a    (pix_a),
    .data_b    (pix_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_pix),
    .count     (fifo_count)
  );

  assign out_blue       = out_pix.blue;
  assign out_green      = out_pix.green;
  assign out_red        = out_pix.red;
  assign out_run_last   = out_pix.run_last;
  assign out_frame_last = out_pix.frame_last;

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last)
    else $error("column counter beyond row end");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    EXT_W'(row_r) <= eff_h)
    else $error("row counter beyond flush row");

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_run_last)
    else $error("frame end pixel not last of its run");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.vld |-> (fifo_count + (FIFO_AW+1)'(s1_n)) <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overrun");
`endif

endmodule
`default_nettype wire

// File: rtl/bbd_line_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_line_mem: line store memory
// Both line stores side by side in one word: upper row high, lower row low.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbd_line_mem #(
  parameter int unsigned DEPTH = bbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [2*bbd_pkg::RAW_W-1:0] rd_data,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [2*bbd_pkg::RAW_W-1:0] wr_data
);
  import bbd_pkg::*;

  logic [2*RAW_W-1:0] mem [DEPTH];
  logic [2*RAW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/bbd_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_interp: 3x3 window and colour interpolation
// Shifts the line store data into the window and forms up to two pixels.
// ----------------------------------------------------------------------------
module bbd_interp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bbd_pkg::s1_ctrl_t  ctrl,
  input  wire bbd_pkg::raw_t      raw,
  input  wire bbd_pkg::raw_t      up,
  input  wire bbd_pkg::raw_t      lo,
  output bbd_pkg::raw_t           nv,
  output bbd_pkg::pix_t           pix_a,
  output bbd_pkg::pix_t           pix_b
);
  import bbd_pkg::*;

  win_t win_r;
  win_t win_nxt;
  raw_t top;
  raw_t a_left_m;
  raw_t a_left_t;
  raw_t a_left_b;

  // flush row mirrors the row above the last; row one mirrors itself upward
  assign nv  = ctrl.flush ? up : raw;
  assign top = ctrl.row1 ? nv : up;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = lo;
    win_nxt[2][2] = nv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctrl.vld) begin
      win_r <= win_nxt;
    end
  end

  // left edge mirrors onto the right neighbour
  assign a_left_m = ctrl.first_col ? win_nxt[1][2] : win_nxt[1][0];
  assign a_left_t = ctrl.first_col ? win_nxt[0][2] : win_nxt[0][0];
  assign a_left_b = ctrl.first_col ? win_nxt[2][2] : win_nxt[2][0];

  assign pix_a = interp(a_left_m, win_nxt[1][2], win_nxt[0][1], win_nxt[2][1],
                        a_left_t, win_nxt[0][2], a_left_b, win_nxt[2][2],
                        win_nxt[1][1], site_t'({ctrl.y_odd, ~ctrl.x_odd}),
                        ~ctrl.last_col, 1'b0);

  assign pix_b = interp(win_nxt[1][1], win_nxt[1][1], win_nxt[0][2], win_nxt[2][2],
                        win_nxt[0][1], win_nxt[0][1], win_nxt[2][1], win_nxt[2][1],
                        win_nxt[1][2], site_t'({ctrl.y_odd, ctrl.x_odd}),
                        1'b1, ctrl.flush);

endmodule
`default_nettype wire

// File: rtl/bbd_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_out_fifo: result queue
// Takes up to two pixels per cycle, hands out one per output transfer.
// ----------------------------------------------------------------------------
module bbd_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push_a,
  input  wire logic                          push_b,
  input  wire bbd_pkg::pix_t                 data_a,
  input  wire bbd_pkg::pix_t                 data_b,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bbd_pkg::pix_t                      out_data,
  output logic [bbd_pkg::FIFO_AW:0]          count
);
  import bbd_pkg::*;

  pix_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic [FIFO_AW:0]   count_nxt;
  logic               pop;

  assign pop        = out_valid && out_ready;
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_a) + FIFO_AW'(push_b);
  assign count_nxt  = count_r + (FIFO_AW+1)'(push_a) + (FIFO_AW+1)'(push_b)
                      - (FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      mem_r[wr_ptr_r + FIFO_AW'(push_a)] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of bayer_bilinear_demosaic
// Raw BGGR frames are streamed in raster order, each followed by its flush
// row. A behavioural demosaic model with its own line stores and window works
// out the colour pixels that every accepted transfer must produce, and the
// monitor compares each output transfer with the oldest of them. Frame sizes
// are rewritten between frames, including clamped, narrowest, widest and
// tallest settings. Wrong-kind items, truncated frames and random back
// pressure on both sides are mixed in.
// ----------------------------------------------------------------------------
module tb;
  import bbd_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_ITEMS  = 150;

  typedef struct packed {
    opcode_t op;
    raw_t    raw;
  } bayer_item_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  opcode_t          in_opcode      = OP_PIXEL;
  raw_t             in_raw_value   = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_red;
  logic             out_run_last;
  logic             out_frame_last;
  logic             cfg_we         = 1'b0;
  reg_idx_t         cfg_index      = REG_WIDTH;
  logic [DIM_W-1:0] cfg_wdata      = '0;

  raw_t             upper_line [MAX_WIDTH_DEF];
  raw_t             lower_line [MAX_WIDTH_DEF];
  raw_t             window [9];
  int unsigned      col_pos        = 0;
  int unsigned      row_pos        = 0;
  logic [DIM_W-1:0] width_reg      = 13'd640;
  logic [DIM_W-1:0] height_reg     = 13'd480;

  bayer_item_t      raw_stream [$];
  pix_t             pending_rgb [$];
  bayer_item_t      next_item;
  int unsigned      send_idle_pct  = 37;
  int unsigned      recv_idle_pct  = 54;
  int unsigned      mismatch_count = 0;
  int unsigned      quiet_cycles   = 0;

  bayer_bilinear_demosaic DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v < 2) return 2;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic pix_t colour_at(int unsigned y, int unsigned x, int unsigned l,
                                     int unsigned m, int unsigned r, logic rl, logic fl);
    int unsigned hs;
    int unsigned vs;
    int unsigned cs;
    int unsigned p;
    pix_t        px;
    hs = 32'(window[3 + l]) + 32'(window[3 + r]);
    vs = 32'(window[m]) + 32'(window[6 + m]);
    cs = (32'(window[l]) + 32'(window[r]) + 32'(window[6 + l]) + 32'(window[6 + r])) / 4;
    p  = 32'(window[3 + m]);
    px.run_last   = rl;
    px.frame_last = fl;
    case (site_t'({y[0], x[0]}))
      SITE_B: begin
        px.red   = PIX_W'(cs >> 2);
        px.green = PIX_W'(((hs + vs) / 4) >> 2);
        px.blue  = PIX_W'(p >> 2);
      end
      SITE_GB: begin
        px.red   = PIX_W'((vs / 2) >> 2);
        px.green = PIX_W'(p >> 2);
        px.blue  = PIX_W'((hs / 2) >> 2);
      end
      SITE_GR: begin
        px.red   = PIX_W'((hs / 2) >> 2);
        px.green = PIX_W'(p >> 2);
        px.blue  = PIX_W'((vs / 2) >> 2);
      end
      default: begin
        px.red   = PIX_W'(p >> 2);
        px.green = PIX_W'(((hs + vs) / 4) >> 2);
        px.blue  = PIX_W'(cs >> 2);
      end
    endcase
    return px;
  endfunction

  function automatic void demosaic_predict(bayer_item_t item);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    logic        flush_row;
    logic        last_col;
    raw_t        up;
    raw_t        lo;
    raw_t        nv;
    raw_t        top;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    x = (col_pos >= w) ? w - 1 : col_pos;
    flush_row = (row_pos >= h);
    // drop items of the wrong kind
    if (item.op != (flush_row ? OP_FLUSH : OP_PIXEL)) return;
    up  = upper_line[x];
    lo  = lower_line[x];
    nv  = flush_row ? up : item.raw;
    top = (row_pos == 1) ? nv : up;
    for (int i = 0; i < 3; i++) begin
      window[3 * i]     = window[3 * i + 1];
      window[3 * i + 1] = window[3 * i + 2];
    end
    window[2] = top;
    window[5] = lo;
    window[8] = nv;
    upper_line[x] = lo;
    lower_line[x] = nv;
    last_col = (x == w - 1);
    if (row_pos >= 1) begin
      if (x >= 1)
        pending_rgb.push_back(colour_at(row_pos - 1, x - 1, (x == 1) ? 2 : 0, 1, 2,
                                        !last_col, 1'b0));
      if (last_col)
        pending_rgb.push_back(colour_at(row_pos - 1, x, 1, 2, 1, 1'b1, flush_row));
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = flush_row ? 0 : row_pos + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic void check_pixel(pix_t got);
    pix_t want;
    if (pending_rgb.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected pixel: b=%0d g=%0d r=%0d run_last=%b frame_last=%b",
                 got.blue, got.green, got.red, got.run_last, got.frame_last);
      return;
    end
    want = pending_rgb.pop_front();
    if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
        got.run_last !== want.run_last || got.frame_last !== want.frame_last) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("pixel mismatch: expected b=%0d g=%0d r=%0d rl=%b fl=%b, got b=%0d g=%0d r=%0d rl=%b fl=%b",
                 want.blue, want.green, want.red, want.run_last, want.frame_last,
                 got.blue, got.green, got.red, got.run_last, got.frame_last);
    end
  endfunction

  function automatic raw_t pick_raw();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 10'h000;
    if (sel == 1) return 10'h3FF;
    return $urandom_range(1023);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(int unsigned big);
    case ($urandom_range(15))
      0: return $urandom_range(1);
      1, 2: return $urandom_range(9, big);
      default: return $urandom_range(2, 7);
    endcase
  endfunction

  function automatic void push_item(opcode_t op, raw_t raw);
    bayer_item_t item;
    item.op  = op;
    item.raw = raw;
    raw_stream.push_back(item);
  endfunction

  // stop_at: real items to send before cutting the frame short, 0 for all
  task automatic queue_frame(int unsigned stop_at, int unsigned noise_pct);
    int unsigned w;
    int unsigned h;
    int unsigned sent;
    opcode_t     kind;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    sent = 0;
    for (int unsigned r = 0; r <= h; r++) begin
      kind = (r == h) ? OP_FLUSH : OP_PIXEL;
      for (int unsigned c = 0; c < w; c++) begin
        if (stop_at != 0 && sent == stop_at) return;
        if ($urandom_range(99) < noise_pct)
          push_item((kind == OP_FLUSH) ? OP_PIXEL : OP_FLUSH, pick_raw());
        push_item(kind, pick_raw());
        sent++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (raw_stream.size() != 0 || in_valid || pending_rgb.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DIM_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_frames(int unsigned goal);
    int unsigned done_items;
    int unsigned total;
    int unsigned frames;
    int unsigned stop_at;
    done_items = 0;
    while (done_items < goal) begin
      wait_drained();
      case ($urandom_range(3))
        0: write_reg(REG_WIDTH, pick_dim(40));
        1: write_reg(REG_HEIGHT, pick_dim(14));
        default: begin
          write_reg(REG_WIDTH, pick_dim(40));
          write_reg(REG_HEIGHT, pick_dim(14));
        end
      endcase
      total = clamp_dim(width_reg, MAX_WIDTH_DEF) * (clamp_dim(height_reg, MAX_HEIGHT_DEF) + 1);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        stop_at = ($urandom_range(7) == 0) ? $urandom_range(1, total - 1) : 0;
        // hold the sender until every pixel has left
        if (f != 0 && $urandom_range(3) == 0) wait_drained();
        queue_frame(stop_at, 4);
        done_items += (stop_at != 0) ? stop_at : total;
        if (stop_at != 0) break;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) demosaic_predict({in_opcode, in_raw_value});
      if (!in_valid || in_ready) begin
        if (raw_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = raw_stream.pop_front();
          in_valid     <= 1'b1;
          in_opcode    <= next_item.op;
          in_raw_value <= next_item.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        check_pixel({out_blue, out_green, out_red, out_run_last, out_frame_last});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("** bayer_bilinear_demosaic: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < 9; i++) window[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size: one full row and the start of the next
    queue_frame(645, 0);
    wait_drained();

    // clamped smallest frame, wrong-kind items at both ends
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 1);
    push_item(OP_FLUSH, 10'h3FF);
    push_item(OP_PIXEL, 10'h3FF);
    push_item(OP_PIXEL, 10'h000);
    push_item(OP_PIXEL, 10'h000);
    push_item(OP_PIXEL, 10'h3FF);
    push_item(OP_FLUSH, 10'h000);
    push_item(OP_PIXEL, 10'h3FF);
    push_item(OP_FLUSH, 10'h3FF);
    wait_drained();

    // odd-sized checkerboard: full-scale colour at every site
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    for (int unsigned i = 0; i < 12; i++)
      push_item((i < 9) ? OP_PIXEL : OP_FLUSH, ((i / 3 + i % 3) % 2 == 0) ? 10'h3FF : 10'h000);
    random_frames(RANDOM_ITEMS);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 37;
    write_reg(REG_WIDTH, 4096);
    write_reg(REG_HEIGHT, 2);
    queue_frame(40, 0);
    random_frames(RANDOM_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // oversized registers clamp to the maximum; cut early in the first row
    write_reg(REG_WIDTH, 8191);
    write_reg(REG_HEIGHT, 8191);
    queue_frame(60, 1);
    wait_drained();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 4096);
    queue_frame(80, 1);
    random_frames(RANDOM_ITEMS);

    wait_drained();
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("** bayer_bilinear_demosaic: PASSED **");
    end else begin
      $display("** bayer_bilinear_demosaic: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bbd_pkg.sv
rtl/bbd_line_mem.sv
rtl/bbd_interp.sv
rtl/bbd_out_fifo.sv
rtl/bayer_bilinear_demosaic.sv
tb/tb.sv
